// ===== rtl/core/hjcc_pkg.sv =====
// Constants, types and jamo classification shared by the jamo cluster composer.
package hjcc_pkg;

  localparam int MAX_JAMOS    = 4;
  localparam int CLUSTER_BITS = 16;
  localparam int CNT_W        = $clog2(MAX_JAMOS + 1);
  localparam int IDX_W        = $clog2(MAX_JAMOS);

  localparam logic [15:0] SYL_BASE   = 16'hAC00;
  localparam logic [20:0] SYL_FIRST  = 21'h00AC00;
  localparam logic [20:0] SYL_END    = 21'h00D7A4;
  localparam logic [12:0] JAMO_BLOCK = 13'h0011;
  localparam logic [7:0]  JAMO_HI    = 8'h11;

  // Low bytes of the jamo ranges (high byte is always 0x11)
  localparam logic [7:0] LEAD_END_B    = 8'h5F;
  localparam logic [7:0] VOWEL_START_B = 8'h60;
  localparam logic [7:0] VOWEL_END_B   = 8'hA2;
  localparam logic [7:0] TRAIL_BASE_B  = 8'hA7;
  localparam logic [7:0] TRAIL_END_B   = 8'hF9;
  localparam logic [7:0] VOWEL_BASE_B  = 8'h61;
  localparam logic [7:0] LEAD_LAST_B   = 8'h12;  // lead index 18
  localparam logic [7:0] VOWEL_LAST_B  = 8'h75;  // vowel index 20
  localparam logic [7:0] TRAIL_LAST_B  = 8'hC2;  // trail index 27

  localparam logic [4:0] VOWEL_COUNT = 5'd21;
  localparam logic [4:0] TRAIL_COUNT = 5'd28;

  typedef enum logic [1:0] {
    CLS_LEAD  = 2'd0,
    CLS_VOWEL = 2'd1,
    CLS_TRAIL = 2'd2,
    CLS_OTHER = 2'd3
  } jamo_cls_t;

  typedef enum logic [1:0] {
    AFTER_END  = 2'd0,
    AFTER_PRE  = 2'd1,
    AFTER_JAMO = 2'd2
  } after_t;

  function automatic jamo_cls_t classify(input logic [7:0] b);
    jamo_cls_t c;
    if (b < LEAD_END_B) begin
      c = CLS_LEAD;
    end else if (b >= VOWEL_START_B && b < VOWEL_END_B) begin
      c = CLS_VOWEL;
    end else if (b >= TRAIL_BASE_B && b < TRAIL_END_B) begin
      c = CLS_TRAIL;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/hangul_jamo_cluster_composer.sv =====
// Hangul jamo cluster composer: buffers conjoining jamos and emits glyph codes per cluster.
//
// Code points enter one per transaction; each result carries a glyph code, the cluster
// number it belongs to and a flag on the last result of its input. A jamo that does not
// close a cluster, and an unknown character, is taken directly in the idle state. An
// input that closes a cluster of N buffered jamos is accepted, then the buffer is scanned
// through its single read port and a decision state follows; a composed syllable then
// passes states MUL1 and MUL2 on the shared multiply-add unit and is emitted once, while
// raw jamos are emitted one result per jamo; a precomposed syllable adds its own emit.
// Emits stall while the output register is held. No clearing pass is needed after reset.
module hangul_jamo_cluster_composer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [20:0] in_code_point,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_glyph_code,
  output logic [15:0] out_cluster_number,
  output logic        out_last_of_run
);
  import hjcc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MUL1,
    S_MUL2,
    S_EMIT_SYL,
    S_EMIT_RAW,
    S_EMIT_PRE
  } state_t;

  state_t                  state_r, state_nxt;
  logic [7:0]              jbuf_r [MAX_JAMOS];
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CLUSTER_BITS-1:0] counter_r, counter_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  jamo_cls_t               prev_cls_r, prev_cls_nxt;
  jamo_cls_t               in_cls_r, in_cls_nxt;
  jamo_cls_t               phase_r, phase_nxt;
  after_t                  after_r, after_nxt;
  logic [15:0]             cp_r, cp_nxt;
  logic [1:0]              nl_r, nl_nxt, nv_r, nv_nxt, nt_r, nt_nxt;
  logic [7:0]              l_b_r, l_b_nxt, v_b_r, v_b_nxt, t_b_r, t_b_nxt;
  logic [13:0]             acc_r, acc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [15:0]             glyph_r, glyph_nxt;
  logic [15:0]             clnum_r, clnum_nxt;
  logic                    last_r, last_nxt;

  logic                    buf_we;
  logic [IDX_W-1:0]        buf_wa;
  logic [7:0]              buf_wd;
  logic [7:0]              rd_byte;
  logic [7:0]              cls_byte;
  jamo_cls_t               cls;
  logic                    slot_free;
  logic                    accept;
  logic                    is_syl, is_jamo, boundary;
  logic                    last_idx;
  logic                    composable;
  logic [4:0]              vi, ti;
  logic [13:0]             mac_a;
  logic [4:0]              mac_k, mac_add;
  logic [13:0]             mac_y;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  assign rd_byte  = jbuf_r[idx_r];
  assign cls_byte = (state_r == S_IDLE) ? in_code_point[7:0] : rd_byte;
  assign cls      = classify(cls_byte);

  assign is_syl  = (in_code_point >= SYL_FIRST) && (in_code_point < SYL_END);
  assign is_jamo = (in_code_point[20:8] == JAMO_BLOCK);
  assign boundary = ((prev_cls_r == CLS_TRAIL) && (cls == CLS_LEAD)) ||
                    ((prev_cls_r == CLS_VOWEL) && (cls == CLS_LEAD)) ||
                    ((prev_cls_r == CLS_TRAIL) && (cls == CLS_VOWEL));

  assign last_idx = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  assign vi = 5'(v_b_r - VOWEL_BASE_B);
  assign ti = (nt_r == 2'd0) ? 5'd0 : 5'(t_b_r - TRAIL_BASE_B);
  assign composable = (nl_r == 2'd1) && (nv_r == 2'd1) && (nt_r <= 2'd1) &&
                      (l_b_r <= LEAD_LAST_B) &&
                      (v_b_r >= VOWEL_BASE_B) && (v_b_r <= VOWEL_LAST_B) &&
                      ((nt_r == 2'd0) ||
                       ((t_b_r >= TRAIL_BASE_B) && (t_b_r <= TRAIL_LAST_B)));

  // Shared multiply-add: lead*21+vowel, then that*28+trail
  always_comb begin
    if (state_r == S_MUL1) begin
      mac_a   = 14'(l_b_r[4:0]);
      mac_k   = VOWEL_COUNT;
      mac_add = vi;
    end else begin
      mac_a   = acc_r;
      mac_k   = TRAIL_COUNT;
      mac_add = ti;
    end
    mac_y = 14'(mac_a * mac_k) + 14'(mac_add);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    counter_nxt   = counter_r;
    idx_nxt       = idx_r;
    prev_cls_nxt  = prev_cls_r;
    in_cls_nxt    = in_cls_r;
    phase_nxt     = phase_r;
    after_nxt     = after_r;
    cp_nxt        = cp_r;
    nl_nxt        = nl_r;
    nv_nxt        = nv_r;
    nt_nxt        = nt_r;
    l_b_nxt       = l_b_r;
    v_b_nxt       = v_b_r;
    t_b_nxt       = t_b_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    glyph_nxt     = glyph_r;
    clnum_nxt     = clnum_r;
    last_nxt      = last_r;
    buf_we        = 1'b0;
    buf_wa        = IDX_W'(count_r);
    buf_wd        = cp_r[7:0];

    case (state_r)
      S_IDLE: begin
        idx_nxt   = '0;
        phase_nxt = CLS_LEAD;
        nl_nxt    = 2'd0;
        nv_nxt    = 2'd0;
        nt_nxt    = 2'd0;
        if (accept) begin
          cp_nxt     = in_code_point[15:0];
          in_cls_nxt = cls;
          if (in_kind) begin
            after_nxt = AFTER_END;
            if (count_r != '0) begin
              state_nxt = S_SCAN;
            end else begin
              counter_nxt = '0;
            end
          end else if (is_syl) begin
            after_nxt = AFTER_PRE;
            state_nxt = (count_r != '0) ? S_SCAN : S_EMIT_PRE;
          end else if (is_jamo) begin
            after_nxt = AFTER_JAMO;
            if (count_r != '0 && (boundary || count_r == CNT_W'(MAX_JAMOS))) begin
              state_nxt = S_SCAN;
            end else begin
              // Buffer the jamo directly
              buf_we       = 1'b1;
              buf_wa       = IDX_W'(count_r);
              buf_wd       = in_code_point[7:0];
              count_nxt    = count_r + CNT_W'(1);
              prev_cls_nxt = cls;
            end
          end
        end
      end

      S_SCAN: begin
        if (idx_r == IDX_W'(0)) l_b_nxt = rd_byte;
        if (idx_r == IDX_W'(1)) v_b_nxt = rd_byte;
        if (idx_r == IDX_W'(2)) t_b_nxt = rd_byte;
        if (phase_r == CLS_LEAD && cls == CLS_LEAD) begin
          nl_nxt = (nl_r == 2'd2) ? nl_r : nl_r + 2'd1;
        end else if (phase_r <= CLS_VOWEL && cls == CLS_VOWEL) begin
          nv_nxt    = (nv_r == 2'd2) ? nv_r : nv_r + 2'd1;
          phase_nxt = CLS_VOWEL;
        end else if (phase_r <= CLS_TRAIL && cls == CLS_TRAIL) begin
          nt_nxt    = (nt_r == 2'd2) ? nt_r : nt_r + 2'd1;
          phase_nxt = CLS_TRAIL;
        end else begin
          phase_nxt = CLS_OTHER;
        end
        if (last_idx) begin
          state_nxt = S_DECIDE;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      S_DECIDE: begin
        state_nxt = composable ? S_MUL1 : S_EMIT_RAW;
      end

      S_MUL1: begin
        acc_nxt   = mac_y;
        state_nxt = S_MUL2;
      end

      S_MUL2: begin
        acc_nxt   = mac_y;
        state_nxt = S_EMIT_SYL;
      end

      S_EMIT_SYL, S_EMIT_RAW: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          clnum_nxt     = 16'(counter_r);
          if (state_r == S_EMIT_SYL) begin
            glyph_nxt = SYL_BASE + 16'(acc_r);
          end else begin
            glyph_nxt = {JAMO_HI, rd_byte};
          end
          if (state_r == S_EMIT_SYL || last_idx) begin
            // Close the cluster and finish the item's own action
            last_nxt  = (after_r != AFTER_PRE);
            count_nxt = '0;
            idx_nxt   = '0;
            state_nxt = S_IDLE;
            case (after_r)
              AFTER_END: begin
                counter_nxt = '0;
              end
              AFTER_PRE: begin
                counter_nxt = counter_r + CLUSTER_BITS'(1);
                state_nxt   = S_EMIT_PRE;
              end
              AFTER_JAMO: begin
                counter_nxt  = counter_r + CLUSTER_BITS'(1);
                buf_we       = 1'b1;
                buf_wa       = '0;
                buf_wd       = cp_r[7:0];
                count_nxt    = CNT_W'(1);
                prev_cls_nxt = in_cls_r;
              end
              default: begin
                counter_nxt = counter_r + CLUSTER_BITS'(1);
              end
            endcase
          end else begin
            last_nxt = 1'b0;
            idx_nxt  = idx_r + IDX_W'(1);
          end
        end
      end

      S_EMIT_PRE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          glyph_nxt     = cp_r;
          clnum_nxt     = 16'(counter_r);
          last_nxt      = 1'b1;
          counter_nxt   = counter_r + CLUSTER_BITS'(1);
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      counter_r   <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      counter_r   <= counter_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prev_cls_r <= prev_cls_nxt;
    in_cls_r   <= in_cls_nxt;
    phase_r    <= phase_nxt;
    after_r    <= after_nxt;
    cp_r       <= cp_nxt;
    nl_r       <= nl_nxt;
    nv_r       <= nv_nxt;
    nt_r       <= nt_nxt;
    l_b_r      <= l_b_nxt;
    v_b_r      <= v_b_nxt;
    t_b_r      <= t_b_nxt;
    acc_r      <= acc_nxt;
    glyph_r    <= glyph_nxt;
    clnum_r    <= clnum_nxt;
    last_r     <= last_nxt;
    if (buf_we) begin
      jbuf_r[buf_wa] <= buf_wd;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_glyph_code     = glyph_r;
  assign out_cluster_number = clnum_r;
  assign out_last_of_run    = last_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_JAMOS))
    else $error("jamo count exceeds buffer depth");

  a_glyph_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (glyph_r[15:8] == JAMO_HI) ||
                    ((glyph_r >= SYL_BASE) && (glyph_r <= 16'hD7A3)))
    else $error("glyph is neither a jamo nor a syllable");

  a_end_resets_counter: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind && count_r == '0) |=> (counter_r == '0))
    else $error("end of text did not restart cluster numbering");

  a_busy_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (count_r != '0))
    else $error("scan started on an empty buffer");

endmodule

// ===== sim/hangul_jamo_cluster_composer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Hangul jamo cluster composer: predicts every glyph per input.
module hangul_jamo_cluster_composer_tb;
  import hjcc_pkg::*;

  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned PHASE_ITEMS  = 60;

  typedef struct packed {
    logic [15:0] glyph;
    logic [15:0] cluster;
    logic        last;
  } glyph_t;

  // Predicts the glyph stream and checks the block's results against it.
  class glyph_scoreboard;
    logic [7:0]  jamo_q [MAX_JAMOS];
    int unsigned jamo_n;
    logic [15:0] cluster_no;
    glyph_t      expected_glyphs[$];
    glyph_t      run[$];
    int unsigned errors;

    function new();
      foreach (jamo_q[k]) jamo_q[k] = '0;
      jamo_n     = 0;
      cluster_no = '0;
      errors     = 0;
    endfunction

    function jamo_cls_t jamo_class(input logic [7:0] b);
      if (b < LEAD_END_B) return CLS_LEAD;
      if (b >= VOWEL_START_B && b < VOWEL_END_B) return CLS_VOWEL;
      if (b >= TRAIL_BASE_B && b < TRAIL_END_B) return CLS_TRAIL;
      return CLS_OTHER;
    endfunction

    function void emit(input logic [15:0] glyph);
      glyph_t g;
      g.glyph   = glyph;
      g.cluster = cluster_no;
      g.last    = 1'b0;
      run.push_back(g);
    endfunction

    // Compose lead+vowel(+trail) into one syllable, else emit the jamos raw.
    function void close_cluster();
      int unsigned i, nl, nv, nt, syl;
      logic [7:0]  l, v, t;
      if (jamo_n == 0) return;
      i  = 0;
      nl = 0;
      nv = 0;
      nt = 0;
      while (i < jamo_n && jamo_class(jamo_q[i]) == CLS_LEAD) begin
        nl++;
        i++;
      end
      while (i < jamo_n && jamo_class(jamo_q[i]) == CLS_VOWEL) begin
        nv++;
        i++;
      end
      while (i < jamo_n && jamo_class(jamo_q[i]) == CLS_TRAIL) begin
        nt++;
        i++;
      end
      l = jamo_q[0];
      v = jamo_q[1];
      t = (nt != 0) ? jamo_q[2] : TRAIL_BASE_B;
      if (nl == 1 && nv == 1 && nt <= 1 && l <= LEAD_LAST_B &&
          v >= VOWEL_BASE_B && v <= VOWEL_LAST_B && t <= TRAIL_LAST_B) begin
        syl = ((int'(l) * VOWEL_COUNT + int'(v - VOWEL_BASE_B)) * TRAIL_COUNT) +
              int'(t - TRAIL_BASE_B) + int'(SYL_BASE);
        emit(syl[15:0]);
      end else begin
        for (int k = 0; k < jamo_n; k++) emit({JAMO_HI, jamo_q[k]});
      end
      cluster_no++;
      jamo_n = 0;
    endfunction

    function void note_input(input logic kind, input logic [20:0] cp);
      jamo_cls_t prev, cur;
      glyph_t    g;
      run.delete();
      if (kind) begin
        close_cluster();
        cluster_no = '0;
      end else if (cp >= SYL_FIRST && cp < SYL_END) begin
        close_cluster();
        emit(cp[15:0]);
        cluster_no++;
      end else if (cp[20:8] == JAMO_BLOCK) begin
        if (jamo_n > 0) begin
          prev = jamo_class(jamo_q[jamo_n - 1]);
          cur  = jamo_class(cp[7:0]);
          if ((prev == CLS_TRAIL && cur == CLS_LEAD) ||
              (prev == CLS_VOWEL && cur == CLS_LEAD) ||
              (prev == CLS_TRAIL && cur == CLS_VOWEL) ||
              jamo_n >= MAX_JAMOS) begin
            close_cluster();
          end
        end
        jamo_q[jamo_n] = cp[7:0];
        jamo_n++;
      end
      if (run.size() > 0) begin
        g = run.pop_back();
        g.last = 1'b1;
        run.push_back(g);
      end
      foreach (run[k]) expected_glyphs.push_back(run[k]);
    endfunction

    function void check_result(input logic [15:0] glyph, input logic [15:0] cluster,
                               input logic last);
      glyph_t e;
      if (expected_glyphs.size() == 0) begin
        $error("unexpected result: glyph_code %h cluster_number %h last_of_run %b",
               glyph, cluster, last);
        errors++;
        return;
      end
      e = expected_glyphs.pop_front();
      if (glyph !== e.glyph) begin
        $error("glyph_code: expected %h, actual %h", e.glyph, glyph);
        errors++;
      end
      if (cluster !== e.cluster) begin
        $error("cluster_number: expected %h, actual %h", e.cluster, cluster);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_of_run: expected %b, actual %b", e.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_glyphs.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [20:0] in_code_point = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_glyph_code;
  logic [15:0] out_cluster_number;
  logic        out_last_of_run;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  glyph_scoreboard sb;

  hangul_jamo_cluster_composer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_code_point     (in_code_point),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_glyph_code    (out_glyph_code),
    .out_cluster_number(out_cluster_number),
    .out_last_of_run   (out_last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_kind, in_code_point);
      if (out_valid && out_ready) begin
        sb.check_result(out_glyph_code, out_cluster_number, out_last_of_run);
      end
    end
  end

  // Abort when no transaction happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("hangul_jamo_cluster_composer regression: fail");
        $finish;
      end
    end
  end

  // Hold valid and payload until the transaction is accepted.
  task automatic send_char(input logic kind, input logic [20:0] cp);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_code_point <= cp;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly well-formed syllables, mixed with loose jamos, syllables, end marks and noise.
  task automatic random_text(input int unsigned n);
    int unsigned sent, pick, li, vi, ti;
    logic [20:0] cp;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        if ($urandom_range(3) == 0) begin
          li = $urandom_range(int'(LEAD_END_B) - 1);
          vi = $urandom_range(int'(VOWEL_END_B) - 1, int'(VOWEL_START_B)) - int'(VOWEL_BASE_B);
          ti = $urandom_range(int'(TRAIL_END_B) - 1, int'(TRAIL_BASE_B)) - int'(TRAIL_BASE_B);
        end else begin
          li = $urandom_range(18);
          vi = $urandom_range(20);
          ti = $urandom_range(27);
        end
        send_char(1'b0, 21'h001100 + 21'(li));
        send_char(1'b0, 21'h001161 + 21'(vi));
        sent += 2;
        if (ti != 0) begin
          send_char(1'b0, 21'h0011A7 + 21'(ti));
          sent++;
        end
      end else if (pick < 55) begin
        send_char(1'b0, SYL_FIRST + 21'($urandom_range(11171)));
        sent++;
      end else if (pick < 65) begin
        send_char(1'b1, 21'($urandom_range(21'h10FFFF)));
        sent++;
      end else if (pick < 85) begin
        send_char(1'b0, 21'h001100 + 21'($urandom_range(255)));
        sent++;
      end else begin
        cp = 21'($urandom_range(21'h10FFFF));
        send_char(1'b0, cp);
        if ((cp >= SYL_FIRST && cp < SYL_END) || cp[20:8] == JAMO_BLOCK) sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: composition extremes, boundaries, dropped tail, full buffer, unknowns.
    send_char(1'b0, 21'h001100);
    send_char(1'b0, 21'h001161);
    send_char(1'b1, 21'h000000);
    send_char(1'b0, 21'h001112);
    send_char(1'b0, 21'h001175);
    send_char(1'b0, 21'h0011C2);
    send_char(1'b0, 21'h00D7A3);
    send_char(1'b0, 21'h00AC00);
    send_char(1'b0, 21'h001100);
    send_char(1'b0, 21'h001161);
    send_char(1'b0, 21'h0011A8);
    send_char(1'b0, 21'h001102);
    send_char(1'b0, 21'h001161);
    send_char(1'b0, 21'h001103);
    send_char(1'b0, 21'h0011A8);
    send_char(1'b0, 21'h001161);
    send_char(1'b1, 21'h1FFFFF);
    send_char(1'b0, 21'h001100);
    send_char(1'b0, 21'h001161);
    send_char(1'b0, 21'h0011A8);
    send_char(1'b0, 21'h0011FA);
    for (int k = 0; k < MAX_JAMOS; k++) send_char(1'b0, 21'h001101);
    send_char(1'b0, 21'h00AC01);
    send_char(1'b0, 21'h10FFFF);
    send_char(1'b0, 21'h001113);
    send_char(1'b0, 21'h001160);
    send_char(1'b1, 21'h000000);
    send_char(1'b1, 21'h000000);

    random_text(PHASE_ITEMS);
    send_idle_pct = 46;
    random_text(PHASE_ITEMS);
    send_idle_pct  = 0;
    recv_stall_pct = 46;
    random_text(PHASE_ITEMS);
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    random_text(PHASE_ITEMS);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_char(1'b0, 21'h001100);
    send_char(1'b0, 21'h001161);
    send_char(1'b1, 21'h000000);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("hangul_jamo_cluster_composer regression: pass");
    end else begin
      $display("hangul_jamo_cluster_composer regression: fail");
    end
    $finish;
  end

endmodule

// ===== hangul_jamo_cluster_composer.f =====
rtl/core/hjcc_pkg.sv
rtl/core/hangul_jamo_cluster_composer.sv
sim/hangul_jamo_cluster_composer_tb.sv
